[rtl/core/pfo_pkg.sv]
// Shared types, color tables and helpers for the palette fade/flash output stage.
package pfo_pkg;

  localparam int PALETTE_ENTRIES = 32;
  localparam int COLOR_W         = $clog2(PALETTE_ENTRIES);
  localparam int FLASH_W         = 8;
  localparam int FADE_W          = 3;
  localparam int FADE_MAX        = 7;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEPS     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_HIGH_ORDER = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [FLASH_W-1:0] flash_t;

  // Word kinds carried on tuser; code 3 is unused and falls to default arms
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_TICK  = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // Access request into the flash counter store
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    flash_t wr_data;
  } flash_req_t;

  localparam color_t DARKER [PALETTE_ENTRIES] = '{
    5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,
    5'd0,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
    5'd7,  5'd14, 5'd15, 5'd16,
    5'd0,  5'd18, 5'd19, 5'd20, 5'd21,
    5'd1,  5'd23, 5'd24, 5'd25, 5'd26,
    5'd1,  5'd28, 5'd29, 5'd30
  };

  localparam color_t LIGHTER [PALETTE_ENTRIES] = '{
    5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd6,
    5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd6,
    5'd15, 5'd16, 5'd17, 5'd13,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd13,
    5'd24, 5'd25, 5'd26, 5'd27, 5'd6,
    5'd29, 5'd30, 5'd31, 5'd6
  };

  // {red, green, blue} per palette entry
  localparam logic [23:0] SHADE_RGB [PALETTE_ENTRIES] = '{
    24'h0e0b16, 24'h1f1a33, 24'h3a3356, 24'h5e587c,
    24'h918bab, 24'hc9c5de, 24'hf7f4ff, 24'h41192b,
    24'h822b43, 24'hcf4140, 24'hf0773f, 24'hffae4a,
    24'hffe06b, 24'hfff6c7, 24'h4f2d23, 24'h8b5533,
    24'hc98f58, 24'hefcb9e, 24'h11303a, 24'h1b5c4a,
    24'h2d9454, 24'h6ccb55, 24'hc6f27e, 24'h182b63,
    24'h2759b3, 24'h3d96e6, 24'h79d6f4, 24'hd0f7ff,
    24'h4d2a7a, 24'h8c54cc, 24'hd97fe2, 24'hffa6c6
  };

  // Walk the darker table once per fade step (at most seven narrow lookups)
  function automatic color_t fade_color(color_t c, logic [FADE_W-1:0] steps);
    color_t v;
    v = c;
    for (int s = 0; s < FADE_MAX; s++) begin
      if (FADE_W'(s) < steps) begin
        v = DARKER[v];
      end
    end
    return v;
  endfunction

  // Two lighter steps while flashing
  function automatic color_t flash_color(color_t c);
    return LIGHTER[LIGHTER[c]];
  endfunction

endpackage

[rtl/core/pfo_flash_store.sv]
// Single-entry flash counter memory with read-before-write forwarding.
module pfo_flash_store (
  input  logic                clk,
  input  logic                rst,
  input  pfo_pkg::flash_req_t req,
  output pfo_pkg::flash_t     flash
);

  pfo_pkg::flash_t flash_mem [0:0];
  logic            mem_valid;
  pfo_pkg::flash_t rd_q;
  logic            rd_valid;
  logic            fwd_hit;
  pfo_pkg::flash_t fwd_data;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      flash_mem[0] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= flash_mem[0];
    end
  end

  // Entry valid bit: an unwritten counter reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        mem_valid <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= mem_valid;
      end
    end
  end

  // A write on the same edge as a read leaves rd_q stale; keep the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req.rd_en) begin
      fwd_hit <= req.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_data <= req.wr_data;
    end
  end

  assign flash = fwd_hit  ? fwd_data :
                 rd_valid ? rd_q     : '0;

endmodule

[rtl/core/palette_fade_flash_output.sv]
// A pixel word passes through stage 1, then the output register; it waits in stage 1 while the output slot is full.
// Throughput: 1 word per cycle unless a pixel word waits on m_tready; the rate is set by the flash counter store's
// read/modify/write loop, which forwards a write-back to the word read on the same edge.
// Tick and load words update the counter; non-pixel words produce no output word.
// Reset (rst, synchronous): pipeline empties, fade_steps = 0, red_high_order = 1,
// and the flash counter reads zero until first written.
module palette_fade_flash_output (
  input  logic                                clk,
  input  logic                                rst,
  // Slave stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,  // [4:0] pixel_index, [15:8] flash_count
  input  logic [1:0]                          s_tuser,  // [1:0] opcode
  // Master stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,  // [31:0] color_word
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [pfo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pfo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [pfo_pkg::FADE_W-1:0] fade_steps;
  logic                       red_high_order;

  logic                 s_accept;
  logic                 s1_valid;
  pfo_pkg::op_t         s1_op;
  pfo_pkg::color_t      s1_color;
  pfo_pkg::flash_t      s1_count;
  logic                 s1_go;
  logic                 out_free;

  pfo_pkg::flash_req_t  flash_req;
  pfo_pkg::flash_t      flash;
  pfo_pkg::color_t      lit_color;
  logic [23:0]          rgb;
  logic [31:0]          color_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_steps     <= '0;
      red_high_order <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pfo_pkg::REG_FADE_STEPS:     fade_steps     <= cfg_data;
        pfo_pkg::REG_RED_HIGH_ORDER: red_high_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: output slot frees when empty or being taken
  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && ((s1_op != pfo_pkg::OP_PIXEL) || out_free);
  assign s_tready = !s1_valid || s1_go;
  assign s_accept = s_tvalid && s_tready;

  // Stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload: darkening is applied on the way in
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_op    <= pfo_pkg::op_t'(s_tuser);
      s1_color <= pfo_pkg::fade_color(s_tdata[pfo_pkg::COLOR_W-1:0], fade_steps);
      s1_count <= s_tdata[15:8];
    end
  end

  // Counter store: read on accept, write back when a tick or load word retires
  always_comb begin
    flash_req.rd_en   = s_accept;
    flash_req.wr_en   = 1'b0;
    flash_req.wr_data = flash;
    case (s1_op)
      pfo_pkg::OP_TICK: begin
        flash_req.wr_en   = s1_go;
        flash_req.wr_data = (flash != '0) ? flash - pfo_pkg::flash_t'(1) : flash;
      end
      pfo_pkg::OP_LOAD: begin
        flash_req.wr_en   = s1_go;
        flash_req.wr_data = s1_count;
      end
      default: ;
    endcase
  end

  pfo_flash_store u_flash_store (
    .clk   (clk),
    .rst   (rst),
    .req   (flash_req),
    .flash (flash)
  );

  // Flash lightening, palette lookup and packing
  always_comb begin
    lit_color = (flash != '0) ? pfo_pkg::flash_color(s1_color) : s1_color;
    rgb       = pfo_pkg::SHADE_RGB[lit_color];
    if (red_high_order) begin
      color_word = {pfo_pkg::ALPHA_OPAQUE, rgb[23:16], rgb[15:8], rgb[7:0]};
    end else begin
      color_word = {pfo_pkg::ALPHA_OPAQUE, rgb[7:0], rgb[15:8], rgb[23:16]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && (s1_op == pfo_pkg::OP_PIXEL)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op == pfo_pkg::OP_PIXEL)) begin
      m_tdata <= color_word;
    end
  end

`ifndef SYNTHESIS
  // Every output word is opaque
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:24] == pfo_pkg::ALPHA_OPAQUE))
    else $error("output word alpha byte not opaque");

  // Counter words never wait on the output side
  a_ctrl_no_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_op != pfo_pkg::OP_PIXEL)) |-> s1_go)
    else $error("counter word stalled in stage 1");

  // The counter is only written by a retiring word
  a_wr_on_retire: assert property (@(posedge clk) disable iff (rst)
    flash_req.wr_en |-> s1_go)
    else $error("counter written without stage 1 retiring");

  // An empty stage 1 always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input not ready with stage 1 empty");

  // A stalled pixel stays in stage 1
  a_pixel_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_color)))
    else $error("stalled pixel lost from stage 1");
`endif

endmodule
